// File: rtl/assert_macros.svh
// assertion macros shared by the slot table rtl
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/grst_pkg.sv
// shared types and constants for the generational request slot table
// no dependencies
package grst_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int OP_W      = 3;
  localparam int HANDLE_W  = 32;
  localparam int BYTES_W   = 24;
  localparam int CODE_W    = 8;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 3'd0,
    OP_APPEND   = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_QUERY    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_FINISHED = 2'd2
  } slot_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_LINK
  } state_t;

  // one row of the slot memory
  typedef struct packed {
    logic                present;
    logic                finished;
    logic [HANDLE_W-1:0] handle;
    logic [CODE_W-1:0]   code;
    logic [BYTES_W-1:0]  used;
    logic [BYTES_W-1:0]  room;
  } slot_entry_t;

endpackage

// File: rtl/grst_ram.sv
// generic single write port, single read port ram with registered read
// depends on grst_pkg for default sizes
module grst_ram #(
  parameter int WIDTH = grst_pkg::HANDLE_W,
  parameter int DEPTH = grst_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/grst_mod.sv
// remainder of a handle by the slot count: reciprocal multiply, then multiply and subtract
// depends on grst_pkg
module grst_mod #(
  parameter int SLOTS = grst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [grst_pkg::HANDLE_W-1:0] value,
  output logic                          done,
  output logic [$clog2(SLOTS)-1:0]      rem
);
  import grst_pkg::*;

  localparam int IW  = $clog2(SLOTS);
  localparam int SH  = HANDLE_W + IW;
  localparam int PRW = 2 * HANDLE_W + 1;
  // rounded-up reciprocal, gives the exact quotient for every handle value
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [HANDLE_W:0] RECIP  = RECIP_FULL[HANDLE_W:0];
  localparam logic [IW-1:0]     DIV_LO = IW'(SLOTS);

  logic                run;
  logic [HANDLE_W-1:0] val;
  logic [HANDLE_W-1:0] quot;
  logic [PRW-1:0]      prod;

  // control: start registers into run, run into done; the remainder is valid with done
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      run  <= start;
      done <= run;
    end
  end

  // quotient by the reciprocal
  always_comb begin
    prod = PRW'(val) * PRW'(RECIP);
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
    end
    if (run) begin
      quot <= HANDLE_W'(prod >> SH);
    end
  end

  // remainder is below the slot count, so the low bits suffice
  assign rem = val[IW-1:0] - quot[IW-1:0] * DIV_LO;

endmodule

// File: rtl/generational_request_slot_table.sv
// Generational request slot table. A request is taken with start while busy is low;
// its result appears on the result ports for one cycle with done high and cannot be
// held off. Allocate, query, append, complete and unused ops read the slot rows,
// then modify and write them back in the execute state, which registers the result.
// A successful release then holds busy through a link state to link the old free
// list tail through the single write port of the link memory. When the slot count is
// not a power of two, requests that carry a handle first pass through a
// remainder unit (a reciprocal multiply, then a short multiply and subtract) to find
// the slot index. A new request may be accepted in the cycle in which the previous
// result is shown, unless a successful release is still linking the free list tail.
// Slot rows are cleared by per-row valid bits at reset; no clearing pass is needed.
// depends on grst_pkg, grst_ram, grst_mod and assert_macros.svh
`include "assert_macros.svh"

module generational_request_slot_table #(
  parameter int SLOTS = grst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [grst_pkg::OP_W-1:0]     op,
  input  logic [grst_pkg::HANDLE_W-1:0] handle_id,
  input  logic [grst_pkg::BYTES_W-1:0]  capacity,
  input  logic [grst_pkg::BYTES_W-1:0]  byte_count,
  input  logic [grst_pkg::CODE_W-1:0]   reply_code,
  output logic                          done,
  output logic [grst_pkg::HANDLE_W-1:0] new_handle,
  output logic                          ok,
  output logic [grst_pkg::STATUS_W-1:0] slot_status,
  output logic [grst_pkg::CODE_W-1:0]   code_out,
  output logic [grst_pkg::BYTES_W-1:0]  used_bytes
);
  import grst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int PW = IW + 1;
  localparam int EW = $bits(slot_entry_t);
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [PW-1:0]       END_PTR   = PW'(SLOTS);
  localparam logic [HANDLE_W-1:0] HANDLE_ST = HANDLE_W'(SLOTS);

  state_t state, state_next;

  // latched request
  op_t                 op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [BYTES_W-1:0]  capacity_q;
  logic [BYTES_W-1:0]  count_q;
  logic [CODE_W-1:0]   code_q;
  logic [IW-1:0]       idx_q;
  logic [IW-1:0]       tail_old;

  logic [PW-1:0]    free_head, free_head_next;
  logic [IW-1:0]    free_tail, free_tail_next;
  logic [SLOTS-1:0] slot_init;
  logic [SLOTS-1:0] link_init;

  logic          accept;
  logic          needs_mod;
  logic          mod_done;
  logic [IW-1:0] mod_rem;
  logic [IW-1:0] rd_addr;
  logic          issue;

  // memory ports
  logic          slot_we;
  slot_entry_t   slot_wdata;
  logic [EW-1:0] slot_rdata;
  slot_entry_t   slot_rd;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic [PW-1:0] link_rdata;

  // slot view after valid bits
  slot_entry_t   ent;
  logic [PW-1:0] nf;
  logic          hit;
  logic          can_alloc;
  logic          room_ok;

  // result values
  logic [HANDLE_W-1:0] res_handle;
  logic                res_ok;
  slot_status_t        res_status;
  logic [CODE_W-1:0]   res_code;
  logic [BYTES_W-1:0]  res_used;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // ops that carry a handle need the remainder unit when the slot count is not a power of two
  always_comb begin
    case (op) inside
      OP_APPEND, OP_COMPLETE, OP_RELEASE, OP_QUERY: needs_mod = !POW2;
      default:                                      needs_mod = 1'b0;
    endcase
  end

  grst_mod #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept && needs_mod),
    .value (handle_id),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // read address for both memories
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = (op == OP_ALLOC) ? free_head[IW-1:0] : handle_id[IW-1:0];
      S_MOD:   rd_addr = mod_rem;
      default: rd_addr = idx_q;
    endcase
  end

  assign issue = (accept && !needs_mod) || (state == S_MOD && mod_done);

  grst_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (idx_q),
    .wdata (slot_wdata),
    .raddr (rd_addr),
    .rdata (slot_rdata)
  );

  grst_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = needs_mod ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (op_q == OP_RELEASE && hit) ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // rows never written read as their reset contents
  always_comb begin
    slot_rd = slot_entry_t'(slot_rdata);
    if (slot_init[idx_q]) begin
      ent = slot_rd;
    end else begin
      ent          = '0;
      ent.handle   = HANDLE_W'(idx_q);
      ent.code     = slot_rd.code;
      ent.used     = slot_rd.used;
      ent.room     = slot_rd.room;
    end
    nf        = link_init[idx_q] ? link_rdata : (PW'(idx_q) + PW'(1));
    hit       = ent.present && (ent.handle == handle_q);
    can_alloc = (free_head < END_PTR) && !ent.present;
    room_ok   = {1'b0, ent.room} >= ({1'b0, count_q} + (BYTES_W+1)'(1));
  end

  // read-modify-write of the slot row, the free list links and the result
  always_comb begin
    slot_we        = 1'b0;
    slot_wdata     = ent;
    link_we        = 1'b0;
    link_waddr     = idx_q;
    link_wdata     = END_PTR;
    free_head_next = free_head;
    free_tail_next = free_tail;
    res_handle     = '0;
    res_ok         = 1'b0;
    res_status     = ST_UNKNOWN;
    res_code       = '0;
    res_used       = '0;
    unique case (state)
      S_EXEC: begin
        case (op_q)
          OP_ALLOC: begin
            if (can_alloc) begin
              slot_we             = 1'b1;
              slot_wdata.handle   = ent.handle + HANDLE_ST;
              slot_wdata.present  = 1'b1;
              slot_wdata.finished = 1'b0;
              slot_wdata.room     = capacity_q;
              slot_wdata.used     = '0;
              free_head_next      = nf;
              res_handle          = ent.handle + HANDLE_ST;
              res_ok              = 1'b1;
              res_status          = ST_PROGRESS;
            end
          end
          OP_APPEND: begin
            if (hit && !ent.finished && room_ok) begin
              slot_we         = 1'b1;
              slot_wdata.room = ent.room - count_q;
              slot_wdata.used = ent.used + count_q;
              res_ok          = 1'b1;
            end
          end
          OP_COMPLETE: begin
            if (hit && !ent.finished) begin
              slot_we             = 1'b1;
              slot_wdata.code     = code_q;
              slot_wdata.finished = 1'b1;
              res_ok              = 1'b1;
            end
          end
          OP_RELEASE: begin
            if (hit) begin
              slot_we            = 1'b1;
              slot_wdata.present = 1'b0;
              link_we            = 1'b1;
              free_tail_next     = idx_q;
              if (free_head >= END_PTR) begin
                free_head_next = PW'(idx_q);
              end
              res_ok = 1'b1;
            end
          end
          OP_QUERY: begin
            if (hit) begin
              res_ok = 1'b1;
              if (ent.finished) begin
                res_status = ST_FINISHED;
                res_code   = ent.code;
                res_used   = ent.used;
              end else begin
                res_status = ST_PROGRESS;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        // old tail points at the released slot, unless it is that slot
        link_we    = (tail_old != idx_q);
        link_waddr = tail_old;
        link_wdata = PW'(idx_q);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      free_tail <= IW'(SLOTS - 1);
      slot_init <= '0;
      link_init <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      free_tail <= free_tail_next;
      done      <= (state == S_EXEC);
      if (slot_we) begin
        slot_init[idx_q] <= 1'b1;
      end
      if (link_we) begin
        link_init[link_waddr] <= 1'b1;
      end
    end
  end

  // request latch and results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op_t'(op);
      handle_q   <= handle_id;
      capacity_q <= capacity;
      count_q    <= byte_count;
      code_q     <= reply_code;
    end
    if (issue) begin
      idx_q <= rd_addr;
    end
    if (state == S_EXEC) begin
      tail_old    <= free_tail;
      new_handle  <= res_handle;
      ok          <= res_ok;
      slot_status <= res_status;
      code_out    <= res_code;
      used_bytes  <= res_used;
    end
  end

  `ASSERT_IMPLY(a_done_after_exec, done, $past(state == S_EXEC), "result without execute")
  `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
  `ASSERT_ALWAYS(a_head_range, free_head <= END_PTR, "free list head out of range")
  `ASSERT_IMPLY(a_link_after_release, state == S_LINK, $past(state == S_EXEC && op_q == OP_RELEASE), "tail link without release")
  `ASSERT_IMPLY(a_mod_done_state, mod_done, state == S_MOD, "remainder done outside wait")

endmodule
